### rtl/dnsa_pkg.sv
// shared constants and types for the dns a-record extractor
package dnsa_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 512;
  localparam int unsigned OFFSET_W = 16;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
  localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_W'(MAX_MESSAGE_BYTES);

  // header byte positions
  localparam logic [OFFSET_W-1:0] HDR_QDCOUNT_HI = OFFSET_W'(4);
  localparam logic [OFFSET_W-1:0] HDR_QDCOUNT_LO = OFFSET_W'(5);
  localparam logic [OFFSET_W-1:0] HDR_ANCOUNT_HI = OFFSET_W'(6);
  localparam logic [OFFSET_W-1:0] HDR_ANCOUNT_LO = OFFSET_W'(7);
  localparam logic [OFFSET_W-1:0] HDR_LAST_BYTE = OFFSET_W'(12 - 1);

  localparam logic [7:0] PTR_MASK = 8'hC0;

  // question tail: type and class, one more byte when the name ended in a pointer
  localparam logic [7:0] QTAIL_AFTER_ZERO = 8'd4;
  localparam logic [7:0] QTAIL_AFTER_PTR = 8'd5;

  // answer fixed part: type(2) class(2) ttl(4) rdlength(2)
  localparam logic [3:0] FIX_CLASS_POS = 4'd2;
  localparam logic [3:0] FIX_TTL_POS = 4'd4;
  localparam logic [3:0] FIX_RDLEN_POS = 4'd8;
  localparam logic [3:0] FIX_LAST_POS = 4'(10 - 1);
  localparam logic [3:0] POS_SAT = 4'd15;

  localparam logic [15:0] TYPE_A = 16'd1;
  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [3:0] A_RDATA_LEN = 4'd4;

  typedef struct packed {
    logic        found;
    logic [31:0] ipv4_address;
  } dnsa_result_t;

endpackage

### rtl/dnsa_in_reg.sv
// input register stage holding one message byte and its last mark
module dnsa_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] msg_byte,
  input  logic       is_last,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_byte,
  output logic       q_last
);
  import dnsa_pkg::*;

  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_byte <= msg_byte;
      q_last <= is_last;
    end
  end

endmodule

### rtl/dnsa_parser.sv
// message walker: header, question skip, answer records and result forming
module dnsa_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [7:0]             q_byte,
  input  logic                   q_last,
  input  logic                   out_free,
  output logic                   step,
  output logic                   res_valid,
  output dnsa_pkg::dnsa_result_t res
);
  import dnsa_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_QNAME, PH_QFIXED, PH_ANAME,
    PH_APTR, PH_AFIXED, PH_RDATA, PH_DONE
  } phase_t;

  phase_t               phase, phase_next;
  logic [OFFSET_W-1:0]  byte_offset, byte_offset_next;
  logic [15:0]          questions_left, questions_left_next;
  logic [15:0]          answers_left, answers_left_next;
  logic [7:0]           label_bytes_left, label_bytes_left_next;
  logic [3:0]           field_position, field_position_next;
  logic [15:0]          record_type, record_type_next;
  logic [15:0]          record_class, record_class_next;
  logic [15:0]          rdata_left, rdata_left_next;
  logic [31:0]          address_accum, address_accum_next;
  logic                 match_seen, match_seen_next;
  logic [31:0]          held_address, held_address_next;
  logic                 rec_end;

  // a last byte needs room in the result register, any other byte always moves
  assign step = q_valid && (!q_last || out_free);
  assign res_valid = step && q_last;

  always_comb begin
    phase_next            = phase;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    label_bytes_left_next = label_bytes_left;
    field_position_next   = field_position;
    record_type_next      = record_type;
    record_class_next     = record_class;
    rdata_left_next       = rdata_left;
    address_accum_next    = address_accum;
    match_seen_next       = match_seen;
    held_address_next     = held_address;
    rec_end               = 1'b0;

    if (byte_offset < OFFSET_LIMIT) begin
      case (phase)
        PH_HEADER: begin
          if (byte_offset == HDR_QDCOUNT_HI || byte_offset == HDR_QDCOUNT_LO) begin
            questions_left_next = {questions_left[7:0], q_byte};
          end else if (byte_offset == HDR_ANCOUNT_HI || byte_offset == HDR_ANCOUNT_LO) begin
            answers_left_next = {answers_left[7:0], q_byte};
          end
          if (byte_offset == HDR_LAST_BYTE) begin
            label_bytes_left_next = '0;
            if (answers_left == '0) begin
              phase_next = PH_DONE;
            end else if (questions_left != '0) begin
              phase_next = PH_QNAME;
            end else begin
              phase_next = PH_ANAME;
            end
          end
        end
        PH_QNAME, PH_ANAME: begin
          if (label_bytes_left != '0) begin
            label_bytes_left_next = label_bytes_left - 8'd1;
          end else if (q_byte == '0) begin
            if (phase == PH_QNAME) begin
              label_bytes_left_next = QTAIL_AFTER_ZERO;
              phase_next = PH_QFIXED;
            end else begin
              field_position_next = '0;
              phase_next = PH_AFIXED;
            end
          end else if ((q_byte & PTR_MASK) == PTR_MASK) begin
            if (phase == PH_QNAME) begin
              label_bytes_left_next = QTAIL_AFTER_PTR;
              phase_next = PH_QFIXED;
            end else begin
              phase_next = PH_APTR;
            end
          end else begin
            label_bytes_left_next = q_byte;
          end
        end
        PH_QFIXED: begin
          if (label_bytes_left != '0) begin
            label_bytes_left_next = label_bytes_left - 8'd1;
          end
          if (label_bytes_left_next == '0) begin
            questions_left_next = questions_left - 16'd1;
            if (questions_left_next == '0) begin
              phase_next = (answers_left != '0) ? PH_ANAME : PH_DONE;
              label_bytes_left_next = '0;
            end else begin
              phase_next = PH_QNAME;
            end
          end
        end
        PH_APTR: begin
          field_position_next = '0;
          phase_next = PH_AFIXED;
        end
        PH_AFIXED: begin
          if (field_position < FIX_CLASS_POS) begin
            record_type_next = {record_type[7:0], q_byte};
          end else if (field_position < FIX_TTL_POS) begin
            record_class_next = {record_class[7:0], q_byte};
          end else if (field_position >= FIX_RDLEN_POS) begin
            rdata_left_next = {rdata_left[7:0], q_byte};
          end
          if (field_position >= FIX_LAST_POS) begin
            field_position_next = '0;
            address_accum_next = '0;
            if (rdata_left_next == '0) begin
              rec_end = 1'b1;
            end else begin
              phase_next = PH_RDATA;
            end
          end else begin
            field_position_next = field_position + 4'd1;
          end
        end
        PH_RDATA: begin
          address_accum_next = {address_accum[23:0], q_byte};
          if (field_position < POS_SAT) begin
            field_position_next = field_position + 4'd1;
          end
          rdata_left_next = rdata_left - 16'd1;
          if (rdata_left_next == '0) begin
            rec_end = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // end of an answer record: take it or move to the next one
      if (rec_end) begin
        if (record_type_next == TYPE_A && record_class_next == CLASS_IN &&
            field_position_next == A_RDATA_LEN) begin
          match_seen_next = 1'b1;
          held_address_next = address_accum_next;
          phase_next = PH_DONE;
        end else begin
          answers_left_next = answers_left - 16'd1;
          field_position_next = '0;
          label_bytes_left_next = '0;
          phase_next = (answers_left_next != '0) ? PH_ANAME : PH_DONE;
        end
      end
    end

    byte_offset_next = (byte_offset < OFFSET_MAX) ? byte_offset + OFFSET_W'(1) : byte_offset;
  end

  always_comb begin
    res.found = match_seen_next;
    res.ipv4_address = match_seen_next ? held_address_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_offset      <= '0;
      questions_left   <= '0;
      answers_left     <= '0;
      label_bytes_left <= '0;
      field_position   <= '0;
      record_type      <= '0;
      record_class     <= '0;
      rdata_left       <= '0;
      address_accum    <= '0;
      match_seen       <= 1'b0;
      held_address     <= '0;
    end else if (step && q_last) begin
      phase            <= PH_HEADER;
      byte_offset      <= '0;
      questions_left   <= '0;
      answers_left     <= '0;
      label_bytes_left <= '0;
      field_position   <= '0;
      record_type      <= '0;
      record_class     <= '0;
      rdata_left       <= '0;
      address_accum    <= '0;
      match_seen       <= 1'b0;
      held_address     <= '0;
    end else if (step) begin
      phase            <= phase_next;
      byte_offset      <= byte_offset_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      label_bytes_left <= label_bytes_left_next;
      field_position   <= field_position_next;
      record_type      <= record_type_next;
      record_class     <= record_class_next;
      rdata_left       <= rdata_left_next;
      address_accum    <= address_accum_next;
      match_seen       <= match_seen_next;
      held_address     <= held_address_next;
    end
  end

  // a match always parks the walker until the end of the message
  a_match_done: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> phase == PH_DONE)
    else $error("match seen outside done phase");

  // rdata phase is only held with bytes still owed
  a_rdata_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RDATA |-> rdata_left != '0)
    else $error("rdata phase with no bytes left");

  // a last byte starts the next message from a clean header
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && q_last |=> byte_offset == '0 && phase == PH_HEADER && !match_seen)
    else $error("walker not cleared after last byte");

endmodule

### rtl/dnsa_out_reg.sv
// result register between the walker and the output channel
module dnsa_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  dnsa_pkg::dnsa_result_t res,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  found,
  output logic [31:0]           ipv4_address
);
  import dnsa_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      found        <= res.found;
      ipv4_address <= res.ipv4_address;
    end
  end

  // no address is ever shown without a match
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> ipv4_address == '0)
    else $error("address shown without a match");

endmodule

### rtl/dns_a_record_extractor_core.sv
// top level of the dns a-record extractor
// takes a dns response one byte per item, with is_last on the final byte, and
// gives exactly one result item per message: found and the ipv4 address of the
// first class in, type a answer record with a four byte rdata that is wholly
// present (address 0 when none). one byte is taken every cycle unless a last
// byte waits; each byte passes an input register and the counter and compare
// logic in the walker, and the result register is loaded as the walker takes
// a last byte. the input keeps flowing while a result waits, and only a last byte
// waits for the result register to free. bytes beyond the message limit in the
// package are not parsed, only their last mark counts. question and answer names
// may end in a zero byte or in a compression pointer after any labels
module dns_a_record_extractor_core (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        is_last,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] ipv4_address
);
  import dnsa_pkg::*;

  logic         q_valid;
  logic [7:0]   q_byte;
  logic         q_last;
  logic         step;
  logic         out_free;
  logic         res_valid;
  dnsa_result_t res;

  // byte register in front of the walker
  dnsa_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .msg_byte (msg_byte),
    .is_last  (is_last),
    .advance  (step),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_last   (q_last)
  );

  // header, question and answer walk, one byte per cycle while no last byte waits
  dnsa_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_byte    (q_byte),
    .q_last    (q_last),
    .out_free  (out_free),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register, parts the walker from a stalled consumer
  dnsa_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .ipv4_address (ipv4_address)
  );

endmodule
